FILE: design/tzr_pkg.sv
package tzr_pkg;

  localparam int RasterSizeDef = 256;
  localparam int AreaW = 18;
  localparam int NumW = 42;
  localparam int QuotW = 17;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TEST  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_SIDE   = 2'd0,
    CFG_METHOD = 2'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EDGE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_READ,
    ST_CMP,
    ST_CDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [NumW-1:0] num;
    logic [NumW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [NumW-1:0] quot;
  } div_rsp_t;

endpackage

FILE: design/tzr_divider.sv
module tzr_divider
  import tzr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] rem_r, rem_nxt;
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [NumW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [NumW:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[NumW-1]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[NumW]) begin
        rem_nxt = trial[NumW-1:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[NumW-2:0], quo_r[NumW-1]};
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

FILE: design/triangle_zbuffer_rasterizer_unit.sv
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | in_tdata: mode, vertices a..c (x,y,z), pixel_x, pixel_y
// out     | out | out_tvalid/tready  | out_tdata: hit, out_x, out_y, depth, red, blue
// cfg     | in  | cfg_we             | cfg_idx, cfg_data
// load, clear, mode 3 and a pixel off the triangle: result set in the edge state, with no divider pass;
// a depth test: one pass of the one-bit-per-cycle divider;
// a win in the gradient method: a second divider pass for the colour.
// after reset a clearing pass writes every depth entry, with no item accepted;
// configuration writes are taken during it.
// one item at a time; in_tready stays low until the result has been taken.
module triangle_zbuffer_rasterizer_unit
  import tzr_pkg::*;
#(
  parameter int RASTER_SIZE = RasterSizeDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,  // mode, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, px, py
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // hit, out_x, out_y, depth_value, red_level, blue_level
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [8:0]   cfg_data
);

  localparam int CoordW = $clog2(RASTER_SIZE);
  localparam int AddrW  = 2 * CoordW;
  localparam int Depth  = RASTER_SIZE * RASTER_SIZE;

  logic [16:0] mem [Depth];
  logic [16:0] rd_q;
  logic        we;
  logic [AddrW-1:0] waddr, raddr, sweep_r, sweep_nxt;
  logic [16:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  state_t st_r, st_nxt;
  logic [8:0] side_r;
  logic       meth_r;
  logic [7:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [15:0] az_r, bz_r, cz_r;
  logic signed [AreaW-1:0] area_r, area_nxt;
  logic [7:0] px_r, py_r;
  logic [1:0] mode_r;
  logic signed [AreaW-1:0] wb_r, wc_r, wa_r;
  logic signed [34:0] pa_r, pb_r, pc_r;
  logic [15:0] dv_r;
  logic [56:0] res_r, res_nxt;
  logic        ov_r, ov_nxt;
  logic        in_rng;

  div_req_t dreq;
  div_rsp_t drsp;

  tzr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [AreaW-1:0] ec, eb, wbn, wcn, absa, wan, ar;
  logic [16:0] q17;
  logic [15:0] dvs;
  logic [11:0] red_g;

  always_comb begin
    ec = AreaW'(($signed({1'b0, bx_r}) - $signed({1'b0, ax_r})) *
                ($signed({1'b0, py_r}) - $signed({1'b0, ay_r})))
       - AreaW'(($signed({1'b0, by_r}) - $signed({1'b0, ay_r})) *
                ($signed({1'b0, px_r}) - $signed({1'b0, ax_r})));
    eb = AreaW'(($signed({1'b0, ax_r}) - $signed({1'b0, cx_r})) *
                ($signed({1'b0, py_r}) - $signed({1'b0, cy_r})))
       - AreaW'(($signed({1'b0, ay_r}) - $signed({1'b0, cy_r})) *
                ($signed({1'b0, px_r}) - $signed({1'b0, cx_r})));
    ar = AreaW'(($signed({1'b0, bx_r}) - $signed({1'b0, ax_r})) *
                ($signed({1'b0, cy_r}) - $signed({1'b0, ay_r})))
       - AreaW'(($signed({1'b0, by_r}) - $signed({1'b0, ay_r})) *
                ($signed({1'b0, cx_r}) - $signed({1'b0, ax_r})));
    absa = area_r[AreaW-1] ? -area_r : area_r;
    wbn  = area_r[AreaW-1] ? -eb : eb;
    wcn  = area_r[AreaW-1] ? -ec : ec;
    wan  = absa - wbn - wcn;
    q17  = drsp.quot[16:0];
    dvs  = q17[16] ? 16'hFFFF : q17[15:0];
    red_g = (drsp.quot > NumW'(4095)) ? 12'hFFF : drsp.quot[11:0];
    in_rng = (32'(px_r) < RASTER_SIZE) && (32'(py_r) < RASTER_SIZE);
  end

  logic [7:0] i_ax, i_ay, i_bx, i_by, i_cx, i_cy, i_px, i_py;
  logic signed [15:0] i_az, i_bz, i_cz;
  assign i_ax = in_tdata[9:2];
  assign i_ay = in_tdata[17:10];
  assign i_az = in_tdata[33:18];
  assign i_bx = in_tdata[41:34];
  assign i_by = in_tdata[49:42];
  assign i_bz = in_tdata[65:50];
  assign i_cx = in_tdata[73:66];
  assign i_cy = in_tdata[81:74];
  assign i_cz = in_tdata[97:82];
  assign i_px = in_tdata[105:98];
  assign i_py = in_tdata[113:106];

  logic [AddrW-1:0] pidx;
  assign pidx = AddrW'(32'(px_r) * RASTER_SIZE + 32'(py_r));

  always_comb begin
    st_nxt    = st_r;
    sweep_nxt = sweep_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    we        = 1'b0;
    waddr     = pidx;
    wdata     = '0;
    raddr     = pidx;
    dreq      = '0;
    in_tready = 1'b0;
    area_nxt  = area_r;
    case (st_r)
      ST_SWEEP: begin
        we        = 1'b1;
        waddr     = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AddrW'(Depth - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = !ov_r;
        if (in_tvalid && !ov_r) st_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        res_nxt = '0;
        case (mode_t'(mode_r))
          MODE_LOAD: begin
            area_nxt = ar;
            ov_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end
          MODE_NONE: begin
            ov_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end
          default: begin
            res_nxt[8:1]  = px_r;
            res_nxt[16:9] = py_r;
            if (!in_rng) begin
              ov_nxt = 1'b1;
              st_nxt = ST_IDLE;
            end else if (mode_r == MODE_CLEAR) begin
              we = 1'b1;
              ov_nxt = 1'b1;
              st_nxt = ST_IDLE;
            end else if (area_r == '0 || wan < 0 || wbn < 0 || wcn < 0) begin
              ov_nxt = 1'b1;
              st_nxt = ST_IDLE;
            end else begin
              st_nxt = ST_MUL;
            end
          end
        endcase
      end
      ST_MUL: st_nxt = ST_SUM;
      ST_SUM: begin
        dreq.start = 1'b1;
        dreq.num   = NumW'(127) * NumW'(pa_r + pb_r + pc_r + (35'(absa) <<< 15));
        dreq.den   = NumW'(absa) << 7;
        st_nxt     = ST_DIV;
      end
      ST_DIV: if (drsp.done) st_nxt = ST_READ;
      ST_READ: st_nxt = ST_CMP;
      ST_CMP: begin
        if (rd_q[16] && rd_q[15:0] >= dv_r) begin
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end else begin
          we    = 1'b1;
          wdata = {1'b1, dv_r};
          res_nxt[0]     = 1'b1;
          res_nxt[32:17] = dv_r;
          if (!meth_r) begin
            res_nxt[44:33] = dv_r[15:4];
            res_nxt[56:45] = '0;
            ov_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = NumW'(px_r) * NumW'(4095);
            dreq.den   = (side_r == '0) ? NumW'(1) : NumW'(side_r);
            st_nxt     = ST_CDIV;
          end
        end
      end
      ST_CDIV: if (drsp.done) begin
        res_nxt[44:33] = red_g;
        res_nxt[56:45] = 12'hFFF - red_g;
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (ov_r && out_tready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_SWEEP;
      sweep_r <= '0;
      ov_r    <= 1'b0;
      side_r  <= 9'd256;
      meth_r  <= 1'b0;
      area_r  <= '0;
      ax_r <= '0; ay_r <= '0; bx_r <= '0; by_r <= '0; cx_r <= '0; cy_r <= '0;
      az_r <= '0; bz_r <= '0; cz_r <= '0;
    end else begin
      st_r    <= st_nxt;
      sweep_r <= sweep_nxt;
      ov_r    <= ov_nxt;
      area_r  <= area_nxt;
      if (cfg_we && cfg_idx == CFG_SIDE) side_r <= cfg_data;
      if (cfg_we && cfg_idx == CFG_METHOD) meth_r <= cfg_data[0];
      if (st_r == ST_IDLE && in_tvalid && !ov_r && in_tdata[1:0] == MODE_LOAD) begin
        ax_r <= i_ax; ay_r <= i_ay; az_r <= i_az;
        bx_r <= i_bx; by_r <= i_by; bz_r <= i_bz;
        cx_r <= i_cx; cy_r <= i_cy; cz_r <= i_cz;
      end
    end
    if (st_r == ST_IDLE && in_tvalid && !ov_r) begin
      mode_r <= in_tdata[1:0];
      px_r   <= i_px;
      py_r   <= i_py;
    end
    if (st_r == ST_EDGE) begin
      wa_r <= wan;
      wb_r <= wbn;
      wc_r <= wcn;
    end
    if (st_r == ST_MUL) begin
      pa_r <= 35'(wa_r) * 35'(az_r);
      pb_r <= 35'(wb_r) * 35'(bz_r);
      pc_r <= 35'(wc_r) * 35'(cz_r);
    end
    if (st_r == ST_DIV && drsp.done) dv_r <= dvs;
    res_r <= res_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, res_r};

endmodule

FILE: tb/triangle_zbuffer_rasterizer_unit_test.sv
`timescale 1ns / 1ps

module triangle_zbuffer_rasterizer_unit_test
  import tzr_pkg::*;
();

  typedef struct packed {
    logic [11:0] blue;
    logic [11:0] red;
    logic [15:0] depth;
    logic [7:0]  py;
    logic [7:0]  px;
    logic        hit;
  } frag_t;

  class frag_scoreboard;
    logic [16:0] zbuf [int];
    longint      vx [3];
    longint      vy [3];
    longint      vz [3];
    longint      area2;
    int          side;
    bit          method;
    frag_t       pending [$];
    int          errors;
    int          hits;
    int          results;

    function new();
      area2 = 0;
      side = 256;
      method = 0;
      errors = 0;
      hits = 0;
      results = 0;
      for (int k = 0; k < 3; k++) begin
        vx[k] = 0;
        vy[k] = 0;
        vz[k] = 0;
      end
    endfunction

    function longint edge_fn(longint ax, longint ay, longint bx, longint by,
                             longint x, longint y);
      return (bx - ax) * (y - ay) - (by - ay) * (x - ax);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [8:0] val);
      if (idx == CFG_SIDE) side = val;
      else if (idx == CFG_METHOD) method = val[0];
    endfunction

    function void note_word(logic [119:0] w);
      mode_t       m;
      frag_t       r;
      int          x;
      int          y;
      int          key;
      longint      a;
      longint      wa;
      longint      wb;
      longint      wc;
      longint      n;
      longint      dv;
      longint      rd;
      int          s;
      m = mode_t'(w[1:0]);
      x = w[105:98];
      y = w[113:106];
      r = '0;
      if (m == MODE_LOAD) begin
        for (int k = 0; k < 3; k++) begin
          vx[k] = w[2 + 32*k +: 8];
          vy[k] = w[10 + 32*k +: 8];
          vz[k] = $signed(w[18 + 32*k +: 16]);
        end
        area2 = edge_fn(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
      end else if (m != MODE_NONE) begin
        r.px = x;
        r.py = y;
        key = x * 256 + y;
        if (m == MODE_CLEAR) begin
          zbuf[key] = '0;
        end else if (area2 != 0) begin
          a = area2;
          wc = edge_fn(vx[0], vy[0], vx[1], vy[1], x, y);
          wb = edge_fn(vx[2], vy[2], vx[0], vy[0], x, y);
          if (a < 0) begin
            a = -a;
            wb = -wb;
            wc = -wc;
          end
          wa = a - wb - wc;
          if (wa >= 0 && wb >= 0 && wc >= 0) begin
            n = wa * vz[0] + wb * vz[1] + wc * vz[2] + 32768 * a;
            dv = (127 * n) / (128 * a);
            if (dv > 65535) dv = 65535;
            if (!(zbuf.exists(key) && zbuf[key][16] && zbuf[key][15:0] >= dv)) begin
              zbuf[key] = {1'b1, dv[15:0]};
              r.hit = 1;
              r.depth = dv[15:0];
              if (!method) begin
                r.red = dv[15:4];
                r.blue = 0;
              end else begin
                s = (side == 0) ? 1 : side;
                rd = (longint'(x) * 4095) / s;
                if (rd > 4095) rd = 4095;
                r.red = rd[11:0];
                r.blue = 4095 - rd[11:0];
              end
            end
          end
        end
      end
      pending = {pending, r};
    endfunction

    function void check_word(logic [63:0] d);
      frag_t got;
      frag_t exp;
      got = d[56:0];
      results++;
      if (got.hit) hits++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", d);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp hit %0d x %0d y %0d z %h r %h b %h,",
                    " got hit %0d x %0d y %0d z %h r %h b %h"},
                   exp.hit, exp.px, exp.py, exp.depth, exp.red, exp.blue,
                   got.hit, got.px, got.py, got.depth, got.red, got.blue);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_idx;
  logic [8:0]   cfg_data;
  longint       cycles = 0;
  bit           draining;
  frag_scoreboard sb;

  triangle_zbuffer_rasterizer_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("triangle_zbuffer_rasterizer_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);

  initial begin
    int w;
    out_tready = 0;
    @(negedge clk);
    forever begin
      w = (!draining && $urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
      out_tready = 0;
      repeat (w) @(negedge clk);
      out_tready = 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic logic [119:0] pack_word(mode_t m, logic [7:0] ax, logic [7:0] ay,
      logic [15:0] az, logic [7:0] bx, logic [7:0] by, logic [15:0] bz, logic [7:0] cx,
      logic [7:0] cy, logic [15:0] cz, logic [7:0] px, logic [7:0] py);
    return {6'd0, py, px, cz, cy, cx, bz, by, bx, az, ay, ax, m};
  endfunction

  task automatic send(logic [119:0] w, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 6) : 0;
    in_tvalid = 0;
    repeat (g) @(negedge clk);
    in_tvalid = 1;
    in_tdata = w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(w);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic wait_empty();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [8:0] val);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic load_tri(logic [7:0] ax, logic [7:0] ay, logic [15:0] az,
      logic [7:0] bx, logic [7:0] by, logic [15:0] bz, logic [7:0] cx, logic [7:0] cy,
      logic [15:0] cz);
    send(pack_word(MODE_LOAD, ax, ay, az, bx, by, bz, cx, cy, cz, 0, 0), 1);
  endtask

  task automatic pix(mode_t m, logic [7:0] x, logic [7:0] y, bit gaps);
    send(pack_word(m, 0, 0, 0, 0, 0, 0, 0, 0, 0, x, y) |
         120'({$urandom(), $urandom(), $urandom(), 2'b0}), gaps);
  endtask

  initial begin
    int bx;
    int by;
    int sz;
    int n;
    sb = new();
    draining = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_idx = CFG_SIDE;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst_n = 1;

    pix(MODE_TEST, 10, 10, 1);
    load_tri(0, 0, 16'h8000, 255, 0, 16'h7fff, 0, 255, 16'h0000);
    pix(MODE_TEST, 0, 0, 1);
    pix(MODE_TEST, 255, 0, 1);
    pix(MODE_TEST, 0, 255, 1);
    pix(MODE_TEST, 0, 0, 1);
    pix(MODE_TEST, 200, 200, 1);
    pix(MODE_CLEAR, 0, 0, 1);
    pix(MODE_TEST, 0, 0, 1);
    load_tri(0, 0, 16'h7fff, 0, 255, 16'h7fff, 255, 255, 16'h7fff);
    pix(MODE_TEST, 10, 200, 1);
    pix(MODE_TEST, 10, 200, 1);
    load_tri(5, 5, 0, 50, 50, 0, 100, 100, 0);
    pix(MODE_TEST, 50, 50, 1);
    send(pack_word(MODE_NONE, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11), 1);
    send({120{1'b1}} & ~(120'd1 << 1), 1);
    send(pack_word(MODE_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hff, 8'hff), 1);
    wait_empty();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_METHOD, 1);
          write_reg(CFG_SIDE, 256);
        end
        1: write_reg(CFG_SIDE, 1);
        2: write_reg(CFG_SIDE, 0);
        3: write_reg(CFG_SIDE, 511);
        4: write_reg(CFG_SIDE, 9'($urandom_range(2, 300)));
        default: begin
          write_reg(CFG_METHOD, 0);
          write_reg(CFG_SIDE, 256);
        end
      endcase
      n = 0;
      while (n < 75) begin
        if ($urandom_range(0, 9) == 0) begin
          send({$urandom(), $urandom(), $urandom(), 24'($urandom())}, 1);
          n++;
          continue;
        end
        sz = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(2, 20);
        bx = $urandom_range(0, 255 - sz);
        by = $urandom_range(0, 255 - sz);
        load_tri(8'(bx + $urandom_range(0, sz)), 8'(by + $urandom_range(0, sz)),
                 16'($urandom()), 8'(bx + $urandom_range(0, sz)),
                 8'(by + $urandom_range(0, sz)), 16'($urandom()),
                 8'(bx + $urandom_range(0, sz)), 8'(by + $urandom_range(0, sz)),
                 16'($urandom()));
        n++;
        for (int k = 0; k < 6; k++) begin
          pix(($urandom_range(0, 7) == 0) ? MODE_CLEAR : MODE_TEST,
              8'(bx + $urandom_range(0, sz)), 8'(by + $urandom_range(0, sz)),
              (ph % 2) == 0);
          n++;
        end
      end
      wait_empty();
    end

    draining = 1;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered %0d results, %0d depth-test wins, across six register settings",
             sb.results, sb.hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("triangle_zbuffer_rasterizer_unit regression: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("triangle_zbuffer_rasterizer_unit regression: fail");
    end
    $finish;
  end
endmodule
